[rtl/bqc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types, widths, register indexes and helpers for the billboard quad
// corner expansion block.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int FRAC_BITS = 16;

    // Right vector components carry two integer bits plus a sign.
    localparam int RW     = FRAC_BITS + 3;
    // Numerator of the normalizing division: (m << FRAC_BITS) + len / 2.
    localparam int NW     = 31 + FRAC_BITS;
    localparam int CNT_W  = ($clog2(NW) > 5) ? $clog2(NW) : 5;
    // Magnitude product width of |r| * width.
    localparam int AMW    = RW + 31;
    // Corner sum width: the up term dominates with 62 - FRAC_BITS bits.
    localparam int SUM_W  = (65 - FRAC_BITS > 35) ? 65 - FRAC_BITS : 35;

    localparam logic [2:0] CFG_UP_X  = 3'd0;
    localparam logic [2:0] CFG_UP_Y  = 3'd1;
    localparam logic [2:0] CFG_UP_Z  = 3'd2;
    localparam logic [2:0] CFG_DIR_X = 3'd3;
    localparam logic [2:0] CFG_DIR_Y = 3'd4;
    localparam logic [2:0] CFG_DIR_Z = 3'd5;

    localparam logic signed [31:0] CAM_UNIT = 32'sd65536;

    typedef logic signed [31:0] word_t;
    typedef word_t [2:0] vec3_t;
    typedef logic signed [RW-1:0] rcomp_t;
    typedef rcomp_t [2:0] rvec3_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        width;
        logic [30:0]        height;
    } bqc_in_t;

    typedef struct packed {
        logic signed [31:0] bl_x;
        logic signed [31:0] bl_y;
        logic signed [31:0] bl_z;
        logic signed [31:0] br_x;
        logic signed [31:0] br_y;
        logic signed [31:0] br_z;
        logic signed [31:0] tl_x;
        logic signed [31:0] tl_y;
        logic signed [31:0] tl_z;
        logic signed [31:0] tr_x;
        logic signed [31:0] tr_y;
        logic signed [31:0] tr_z;
    } bqc_out_t;

    typedef struct packed {
        logic busy;
    } rvec_status_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_CROSS_A,
        R_CROSS_B,
        R_NORM,
        R_SQ,
        R_SQRT,
        R_DIV_LOAD,
        R_DIV
    } rvec_state_t;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(32'sh80000000);

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/billboard_quad_corners_top.sv]
`timescale 1ns / 1ps
// Throughput is one item per cycle while in_ready is high and output does not stall.
// The right vector is recomputed by a shared sequential unit after reset and after
// every configuration write (cross product, up to 34 shift steps, 32 square-root
// steps, three 47-step divisions); in_ready stays low meanwhile.
// Reset (rst_n, asynchronous, active low) loads up = (0, 1, 0) and dir = (0, 0, 1).
// ----------------------------------------------------------------------------
// billboard_quad_corners_top
// Expands a camera-facing billboard into its four corner points.
// ----------------------------------------------------------------------------
module billboard_quad_corners_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bqc_pkg::bqc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bqc_pkg::bqc_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import bqc_pkg::*;

    vec3_t        up_reg, dir_reg;
    rvec3_t       rvec;
    rvec_status_t rstat;
    logic         cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= {32'sd0, CAM_UNIT, 32'sd0};
            dir_reg <= {CAM_UNIT, 32'sd0, 32'sd0};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_UP_X:  up_reg[0]  <= cfg_data;
                CFG_UP_Y:  up_reg[1]  <= cfg_data;
                CFG_UP_Z:  up_reg[2]  <= cfg_data;
                CFG_DIR_X: dir_reg[0] <= cfg_data;
                CFG_DIR_Y: dir_reg[1] <= cfg_data;
                CFG_DIR_Z: dir_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bqc_rvec u_rvec (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_write),
        .up     (up_reg),
        .dir    (dir_reg),
        .rvec   (rvec),
        .status (rstat)
    );

    // Items wait while the right vector is stale.
    bqc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (rstat.busy || cfg_write),
        .rvec      (rvec),
        .up        (up_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/bqc_rvec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_rvec
// Sequencer that forms the unit right vector from the camera up and view
// direction vectors: cross product, normalization, square root, division.
// ----------------------------------------------------------------------------
module bqc_rvec (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bqc_pkg::vec3_t   up,
    input  bqc_pkg::vec3_t   dir,
    output bqc_pkg::rvec3_t  rvec,
    output bqc_pkg::rvec_status_t status
);
    import bqc_pkg::*;

    rvec_state_t        state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [63:0]        mag_reg [3];
    logic [63:0]        mag_next [3];
    logic [2:0]         sgn_reg, sgn_next;
    logic [63:0]        ss_reg, ss_next;
    logic [63:0]        res_reg, res_next;
    logic [31:0]        rem_reg, rem_next;
    logic [NW-1:0]      num_reg, num_next;
    rvec3_t             r_reg, r_next;

    logic signed [31:0] a1, b1, a2, b2;
    logic signed [63:0] diff;
    logic [63:0]        mx;
    logic [63:0]        bitv;
    logic [63:0]        trial_sum;
    logic [32:0]        trial;
    logic               ge;
    logic [29:0]        msel;
    logic [RW-1:0]      quo;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:
            begin
                a1 = up[1]; b1 = dir[2]; a2 = up[2]; b2 = dir[1];
            end
            2'd1:
            begin
                a1 = up[2]; b1 = dir[0]; a2 = up[0]; b2 = dir[2];
            end
            default:
            begin
                a1 = up[0]; b1 = dir[1]; a2 = up[1]; b2 = dir[0];
            end
        endcase
    end

    always_comb
    begin
        diff = prod_reg - (64'(a2) * 64'(b2));
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
            mx = mag_reg[1];
        if (mag_reg[2] > mx)
            mx = mag_reg[2];
        bitv      = 64'd1 << {cnt_reg[4:0], 1'b0};
        trial_sum = res_reg + bitv;
        trial     = {rem_reg, num_reg[NW-1]};
        ge        = trial >= {1'b0, res_reg[31:0]};
        msel      = mag_reg[idx_reg][29:0];
        quo       = {num_reg[RW-2:0], ge};
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mag_next   = mag_reg;
        sgn_next   = sgn_reg;
        ss_next    = ss_reg;
        res_next   = res_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        r_next     = r_reg;

        unique case (state_reg)
            R_IDLE:
            begin
            end
            R_CROSS_A:
            begin
                prod_next  = 64'(a1) * 64'(b1);
                state_next = R_CROSS_B;
            end
            R_CROSS_B:
            begin
                sgn_next[idx_reg] = diff[63];
                mag_next[idx_reg] = diff[63] ? 64'(-diff) : 64'(diff);
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = R_NORM;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = R_CROSS_A;
                end
            end
            R_NORM:
            begin
                // One bit of shift per cycle until the largest magnitude
                // sits in [2^29, 2^30).
                if (mx == 64'd0)
                begin
                    r_next     = '0;
                    state_next = R_IDLE;
                end
                else if (mx >= (64'd1 << 30))
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (mx < (64'd1 << 29))
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    ss_next    = '0;
                    idx_next   = 2'd0;
                    state_next = R_SQ;
                end
            end
            R_SQ:
            begin
                ss_next = ss_reg + 64'(msel) * 64'(msel);
                if (idx_reg == 2'd2)
                begin
                    res_next   = '0;
                    cnt_next   = CNT_W'(31);
                    state_next = R_SQRT;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            R_SQRT:
            begin
                if (ss_reg >= trial_sum)
                begin
                    ss_next  = ss_reg - trial_sum;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                if (cnt_reg == '0)
                begin
                    idx_next   = 2'd0;
                    state_next = R_DIV_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            R_DIV_LOAD:
            begin
                num_next   = (NW'(msel) << FRAC_BITS) + NW'(res_reg[31:1]);
                rem_next   = '0;
                cnt_next   = CNT_W'(NW - 1);
                state_next = R_DIV;
            end
            R_DIV:
            begin
                rem_next = ge ? 32'(trial - {1'b0, res_reg[31:0]}) : trial[31:0];
                num_next = {num_reg[NW-2:0], ge};
                if (cnt_reg == '0)
                begin
                    r_next[idx_reg] = sgn_reg[idx_reg] ? rcomp_t'(-quo) : rcomp_t'(quo);
                    if (idx_reg == 2'd2)
                    begin
                        state_next = R_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = R_DIV_LOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase

        if (start)
        begin
            idx_next   = 2'd0;
            state_next = R_CROSS_A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_CROSS_A;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        mag_reg  <= mag_next;
        sgn_reg  <= sgn_next;
        ss_reg   <= ss_next;
        res_reg  <= res_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        r_reg    <= r_next;
    end

    assign rvec        = r_reg;
    assign status.busy = (state_reg != R_IDLE);

endmodule

[rtl/bqc_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pipe
// Four-stage corner pipeline: input capture, half-extent products, rounding,
// corner sums with saturation.
// ----------------------------------------------------------------------------
module bqc_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  bqc_pkg::rvec3_t   rvec,
    input  bqc_pkg::vec3_t    up,
    input  logic              in_valid,
    output logic              in_ready,
    input  bqc_pkg::bqc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bqc_pkg::bqc_out_t out_data
);
    import bqc_pkg::*;

    logic     en;
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    bqc_in_t  s1_reg;
    bqc_out_t out_reg, out_next;

    logic signed [31:0]      ctr1 [3];
    logic signed [31:0]      ctr2_reg [3];
    logic signed [31:0]      ctr3_reg [3];
    logic [AMW-1:0]          amag2_reg [3];
    logic [62:0]             bmag2_reg [3];
    logic [2:0]              asg2_reg, bsg2_reg;
    logic signed [SUM_W-1:0] a3_reg [3];
    logic signed [SUM_W-1:0] b3_reg [3];

    logic [RW-1:0]           rabs [3];
    logic [31:0]             uabs [3];
    logic [AMW:0]            arnd [3];
    logic [63:0]             brnd [3];
    logic signed [SUM_W-1:0] c4 [3];
    logic signed [31:0]      bl [3], br [3], tl [3], tr [3];

    assign en        = !v4_reg || out_ready;
    assign in_ready  = en && !hold;
    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    assign ctr1[0] = s1_reg.center_x;
    assign ctr1[1] = s1_reg.center_y;
    assign ctr1[2] = s1_reg.center_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rabs[i] = rvec[i][RW-1] ? RW'(-rvec[i]) : RW'(rvec[i]);
            uabs[i] = up[i][31] ? 32'(-up[i]) : 32'(up[i]);
            // Round half away from zero on the magnitude, then shift by one
            // extra bit for the halving.
            arnd[i] = ((AMW+1)'(amag2_reg[i]) + ((AMW+1)'(1) << FRAC_BITS))
                      >> (FRAC_BITS + 1);
            brnd[i] = (64'(bmag2_reg[i]) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
            c4[i]   = SUM_W'(ctr3_reg[i]);
            bl[i]   = sat32(c4[i] - a3_reg[i] - b3_reg[i]);
            br[i]   = sat32(c4[i] + a3_reg[i] - b3_reg[i]);
            tl[i]   = sat32(c4[i] - a3_reg[i] + b3_reg[i]);
            tr[i]   = sat32(c4[i] + a3_reg[i] + b3_reg[i]);
        end
        out_next.bl_x = bl[0]; out_next.bl_y = bl[1]; out_next.bl_z = bl[2];
        out_next.br_x = br[0]; out_next.br_y = br[1]; out_next.br_z = br[2];
        out_next.tl_x = tl[0]; out_next.tl_y = tl[1]; out_next.tl_z = tl[2];
        out_next.tr_x = tr[0]; out_next.tr_y = tr[1]; out_next.tr_z = tr[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && !hold;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= in_data;
            for (int i = 0; i < 3; i++)
            begin
                ctr2_reg[i]  <= ctr1[i];
                amag2_reg[i] <= AMW'(rabs[i]) * AMW'(s1_reg.width);
                bmag2_reg[i] <= 63'(uabs[i]) * 63'(i == 0 ? s1_reg.height :
                                                  i == 1 ? s1_reg.height :
                                                           s1_reg.height);
                asg2_reg[i]  <= rvec[i][RW-1];
                bsg2_reg[i]  <= up[i][31];
                ctr3_reg[i]  <= ctr2_reg[i];
                a3_reg[i]    <= asg2_reg[i] ? -SUM_W'(arnd[i]) : SUM_W'(arnd[i]);
                b3_reg[i]    <= bsg2_reg[i] ? -SUM_W'(brnd[i]) : SUM_W'(brnd[i]);
            end
            out_reg <= out_next;
        end
    end

endmodule

[rtl/bqc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks for the billboard quad corner block, bound to the top.
// ----------------------------------------------------------------------------
module bqc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input bqc_pkg::bqc_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);
    import bqc_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A register write makes the right vector stale, so no item may enter next cycle.
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input taken while right vector is recomputed");

    // A full output stage stalls the whole pipeline.
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline is stalled");

    // A result cannot appear in the cycle right after reset.
    a_no_early: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight out of reset");

endmodule

bind billboard_quad_corners_top bqc_checker u_bqc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
